>>> design/pttt_pkg.sv
`default_nettype none
package pttt_pkg;

	localparam int ID_W        = 16;
	localparam int CNT_W       = 16;
	localparam int MAX_REPORTS = 16;
	localparam int RPT_W       = $clog2(MAX_REPORTS + 1);

	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_PAD_W  = OUT_DATA_W - ID_W - 3;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_TICK   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_NULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] period;
		logic [CNT_W-1:0] cd;
	} slot_word_t;

	typedef struct packed {
		logic             hit;
		logic             free;
		logic             fire;
		logic [CNT_W-1:0] cd_next;
	} slot_eval_t;

endpackage
`default_nettype wire

>>> design/periodic_task_tick_table_core.sv
`default_nettype none
// Periodic task table. Each request beat (tuser selects add, remove or tick) is
// served by one scan of the slot memory, one slot per cycle through a single
// shared compare/countdown unit, unless a full output register holds the scan.
// An add or remove with a null id, and the unused request code, skip the scan.
// Only one request is in work at a time; s_axis_tready is high while the
// sequencer is idle, even if the last result beat still waits in the output
// register. A tick gives one beat per fired task in slot order (at most sixteen
// are reported, all of them reload), or one beat with fired_valid low when
// nothing fired; tlast marks the final beat. Slot contents sit in a memory with
// a registered read port; occupancy is kept in flip-flops cleared by reset, so
// no clearing pass is needed.
module periodic_task_tick_table_core #(
	parameter int SLOTS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [15:0] task_id, [31:16] period_ms
	input  wire logic [pttt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [1:0] req_type
	input  wire logic [pttt_pkg::IN_USER_W-1:0]    s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [2:0] status, [18:3] fired_id, [23:19] zero
	output logic [pttt_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// [0] fired_valid
	output logic [0:0]                             m_axis_tuser,
	output logic                                   m_axis_tlast
);
	import pttt_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	// Sequencer and request registers.
	state_t           state_q, state_d;
	req_t             req_q;
	logic [ID_W-1:0]  id_q;
	logic [CNT_W-1:0] per_q;
	logic [CW-1:0]    idx_q;

	// Slot storage: contents in memory, occupancy in flops.
	slot_word_t       slot_mem [SLOTS];
	logic [SLOTS-1:0] occ_q;

	// Read stage.
	logic             vld_s1;
	logic [AW-1:0]    idx_s1;
	slot_word_t       rd_s1;
	slot_eval_t       ev;

	// Scan results.
	logic             hit_q, free_q;
	logic [AW-1:0]    hit_idx_q, free_idx_q;

	// The most recent fired id is held back until we know whether it is the last.
	logic             pend_vld_q;
	logic [ID_W-1:0]  pend_id_q;
	logic [RPT_W-1:0] rpt_q;

	// Output register.
	logic             obuf_vld_q;
	status_t          obuf_status_q;
	logic [ID_W-1:0]  obuf_id_q;
	logic             obuf_user_q;
	logic             obuf_last_q;

	logic    accept, obuf_free, rep, push_pend, stall, adv, issue, tick_wr;
	logic    fin_go, add_wr, rem_clr, scan_needed;
	status_t fin_status;

	pttt_slot_unit u_slot_unit (
		.occ  (occ_q[idx_s1]),
		.id   (id_q),
		.word (rd_s1),
		.ev   (ev)
	);

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign obuf_free = !obuf_vld_q || m_axis_tready;

	// A fired slot is reported while fewer than the maximum have been reported;
	// pushing the held id out needs a free output register, otherwise the scan waits.
	assign rep       = vld_s1 && (req_q == REQ_TICK) && ev.fire && (rpt_q < RPT_W'(MAX_REPORTS));
	assign push_pend = rep && pend_vld_q;
	assign stall     = push_pend && !obuf_free;
	assign adv       = (state_q == S_SCAN) && !stall;
	assign issue     = idx_q < CW'(SLOTS);
	assign tick_wr   = adv && vld_s1 && (req_q == REQ_TICK);

	assign scan_needed = (req_t'(s_axis_tuser) == REQ_TICK) ||
		(((req_t'(s_axis_tuser) == REQ_ADD) || (req_t'(s_axis_tuser) == REQ_REMOVE)) &&
		 (s_axis_tdata[ID_W-1:0] != '0));

	// Final status of the request, from what the scan found.
	always_comb begin
		case (req_q)
			REQ_ADD: begin
				if (id_q == '0) begin
					fin_status = ST_NULL;
				end else if (hit_q) begin
					fin_status = ST_DUP;
				end else if (!free_q) begin
					fin_status = ST_FULL;
				end else begin
					fin_status = ST_DONE;
				end
			end
			REQ_REMOVE: begin
				if (id_q == '0) begin
					fin_status = ST_NULL;
				end else if (!hit_q) begin
					fin_status = ST_NOTFOUND;
				end else begin
					fin_status = ST_DONE;
				end
			end
			default: fin_status = ST_DONE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		fin_go  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = scan_needed ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				s_axis_tready = 1'b0;
				if (!issue && !vld_s1) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				s_axis_tready = 1'b0;
				fin_go        = obuf_free;
				if (obuf_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				s_axis_tready = 1'b0;
				state_d       = S_IDLE;
			end
		endcase
	end

	assign add_wr  = fin_go && (req_q == REQ_ADD) && (fin_status == ST_DONE);
	assign rem_clr = fin_go && (req_q == REQ_REMOVE) && (fin_status == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			occ_q      <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			rpt_q      <= '0;
			obuf_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q      <= '0;
				vld_s1     <= 1'b0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
				pend_vld_q <= 1'b0;
				rpt_q      <= '0;
			end else if (adv) begin
				vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (vld_s1 && ev.hit && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (vld_s1 && ev.free && !free_q) begin
					free_q <= 1'b1;
				end
				if (rep) begin
					pend_vld_q <= 1'b1;
					rpt_q      <= rpt_q + RPT_W'(1);
				end
			end
			if (add_wr) begin
				occ_q[free_idx_q] <= 1'b1;
			end else if (rem_clr) begin
				occ_q[hit_idx_q] <= 1'b0;
			end
			if ((adv && push_pend) || fin_go) begin
				obuf_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				obuf_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers and the slot memory.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(s_axis_tuser);
			id_q  <= s_axis_tdata[ID_W-1:0];
			per_q <= s_axis_tdata[ID_W+CNT_W-1:ID_W];
		end
		if (adv) begin
			if (issue) begin
				rd_s1  <= slot_mem[idx_q[AW-1:0]];
				idx_s1 <= idx_q[AW-1:0];
			end
			if (vld_s1 && ev.hit && !hit_q) begin
				hit_idx_q <= idx_s1;
			end
			if (vld_s1 && ev.free && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (rep) begin
				pend_id_q <= rd_s1.id;
			end
		end
		if (tick_wr) begin
			slot_mem[idx_s1] <= '{id: rd_s1.id, period: rd_s1.period, cd: ev.cd_next};
		end else if (add_wr) begin
			slot_mem[free_idx_q] <= '{id: id_q, period: per_q, cd: CNT_W'(1)};
		end
		if (adv && push_pend) begin
			obuf_status_q <= ST_DONE;
			obuf_id_q     <= pend_id_q;
			obuf_user_q   <= 1'b1;
			obuf_last_q   <= 1'b0;
		end else if (fin_go) begin
			obuf_status_q <= fin_status;
			obuf_last_q   <= 1'b1;
			if ((req_q == REQ_TICK) && pend_vld_q) begin
				obuf_id_q   <= pend_id_q;
				obuf_user_q <= 1'b1;
			end else begin
				obuf_id_q   <= '0;
				obuf_user_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid   = obuf_vld_q;
	assign m_axis_tdata    = {{OUT_PAD_W{1'b0}}, obuf_id_q, obuf_status_q};
	assign m_axis_tuser[0] = obuf_user_q;
	assign m_axis_tlast    = obuf_last_q;

endmodule
`default_nettype wire

>>> design/pttt_slot_unit.sv
`default_nettype none
// Shared per-slot evaluator: id compare, free check and the countdown step.
module pttt_slot_unit (
	input  wire logic                     occ,
	input  wire logic [pttt_pkg::ID_W-1:0] id,
	input  wire pttt_pkg::slot_word_t     word,
	output pttt_pkg::slot_eval_t          ev
);
	import pttt_pkg::*;

	logic expire;

	always_comb begin
		expire     = (word.cd <= CNT_W'(1));
		ev.hit     = occ && (word.id == id);
		ev.free    = !occ;
		ev.fire    = occ && expire;
		if (expire) begin
			ev.cd_next = (word.period == '0) ? CNT_W'(1) : word.period;
		end else begin
			ev.cd_next = word.cd - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

>>> bench/tick_table_checker.sv
`timescale 1ns / 100ps
// Watches both streams of the task table, keeps its own copy of the slot
// table and compares every result beat with the oldest outstanding one.
module tick_table_checker #(
	parameter int SLOTS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	input  wire logic                            s_axis_tready,
	input  wire logic [pttt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic [pttt_pkg::IN_USER_W-1:0]  s_axis_tuser,
	input  wire logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	input  wire logic [pttt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  wire logic [0:0]                      m_axis_tuser,
	input  wire logic                            m_axis_tlast,
	output int                                   mismatches,
	output int                                   owed_beats,
	output int                                   beats_checked
);
	import pttt_pkg::*;

	typedef struct packed {
		status_t         status;
		logic            fired;
		logic [ID_W-1:0] id;
		logic            last;
	} report_t;

	localparam int SHOW_MAX = 40;

	report_t           report_q[$];
	logic [ID_W-1:0]   slot_id[SLOTS];
	logic [CNT_W-1:0]  slot_period[SLOTS];
	logic [CNT_W-1:0]  slot_count[SLOTS];
	int                err_count;
	int                beat_count;

	// Applies one request to the table copy and queues the beats it must produce.
	task automatic serve_request(input req_t req, input logic [ID_W-1:0] id,
			input logic [CNT_W-1:0] period);
		status_t st;
		int      hit_slot;
		int      free_slot;
		int      nfired;
		report_t burst[MAX_REPORTS];
		st = ST_DONE;
		hit_slot = -1;
		free_slot = -1;
		nfired = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (id != '0 && slot_id[i] == id && hit_slot < 0)
				hit_slot = i;
			if (slot_id[i] == '0 && free_slot < 0)
				free_slot = i;
		end
		case (req)
			REQ_ADD: begin
				if (id == '0)
					st = ST_NULL;
				else if (hit_slot >= 0)
					st = ST_DUP;
				else if (free_slot < 0)
					st = ST_FULL;
				else begin
					slot_id[free_slot] = id;
					slot_period[free_slot] = period;
					slot_count[free_slot] = CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (id == '0)
					st = ST_NULL;
				else if (hit_slot < 0)
					st = ST_NOTFOUND;
				else
					slot_id[hit_slot] = '0;
			end
			REQ_TICK: begin
				// Free slots keep counting; they just never report.
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_count[i] <= 1) begin
						if (slot_id[i] != '0 && nfired < MAX_REPORTS) begin
							burst[nfired] = '{ST_DONE, 1'b1, slot_id[i], 1'b0};
							nfired++;
						end
						slot_count[i] = (slot_period[i] == '0) ? CNT_W'(1) : slot_period[i];
					end else begin
						slot_count[i] = slot_count[i] - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (req != REQ_TICK || nfired == 0) begin
			report_q.push_back('{st, 1'b0, ID_W'(0), 1'b1});
		end else begin
			burst[nfired - 1].last = 1'b1;
			for (int i = 0; i < nfired; i++)
				report_q.push_back(burst[i]);
		end
	endtask

	task automatic check_beat();
		report_t got;
		report_t want;
		got.status = status_t'(m_axis_tdata[2:0]);
		got.fired = m_axis_tuser[0];
		got.id = m_axis_tdata[ID_W+2:3];
		got.last = m_axis_tlast;
		beat_count++;
		if (report_q.size() == 0) begin
			err_count++;
			if (err_count <= SHOW_MAX)
				$display("%0t: unexpected beat: status=%0d fired=%b id=%h last=%b",
					$time, got.status, got.fired, got.id, got.last);
		end else begin
			want = report_q.pop_front();
			if (got !== want) begin
				err_count++;
				if (err_count <= SHOW_MAX)
					$display("%0t: expected st=%0d v=%b id=%h l=%b, got st=%0d v=%b id=%h l=%b",
						$time, want.status, want.fired, want.id, want.last,
						got.status, got.fired, got.id, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_id[i] = '0;
				slot_period[i] = '0;
				slot_count[i] = '0;
			end
			report_q.delete();
			err_count = 0;
			beat_count = 0;
			mismatches <= 0;
			owed_beats <= 0;
			beats_checked <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_beat();
			if (s_axis_tvalid && s_axis_tready)
				serve_request(req_t'(s_axis_tuser), s_axis_tdata[ID_W-1:0],
					s_axis_tdata[ID_W+CNT_W-1:ID_W]);
			mismatches <= err_count;
			owed_beats <= report_q.size();
			beats_checked <= beat_count;
		end
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Top of the task table bench. It makes the request stream, paces the result
// side and gives the verdict; all prediction and comparison live in the checker.
module tb;
	import pttt_pkg::*;

	localparam int SLOTS = 16;
	// A generous ceiling: roughly 170 requests, each a full scan plus up to sixteen
	// result beats under heavy back-pressure, comes to far less than this.
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 36;
	localparam int POOL_SIZE = 24;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [15:0] task_id, [31:16] period_ms
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// [1:0] req_type
	logic [IN_USER_W-1:0]  s_axis_tuser = REQ_NONE;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b1;
	// [2:0] status, [18:3] fired_id, [23:19] zero
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// [0] fired_valid
	logic [0:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	int mismatches;
	int owed_beats;
	int beats_checked;
	int requests_sent = 0;
	int cycle_count = 0;
	// Percentages of cycles in which the sender idles or the receiver stalls.
	int src_gap_pct = 0;
	int sink_stall_pct = 0;

	logic [ID_W-1:0] id_pool[POOL_SIZE];

	periodic_task_tick_table_core #(
		.SLOTS(SLOTS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	tick_table_checker #(
		.SLOTS(SLOTS)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.mismatches   (mismatches),
		.owed_beats   (owed_beats),
		.beats_checked(beats_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The receiver decides its ready for the next edge at every edge, so a
	// stall can land on any beat of a tick burst.
	initial begin
		forever begin
			@(posedge clk);
			m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Watchdog. It runs to the limit only if the stream hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
		$display("tb failed");
		$finish;
	end

	// Presents one request beat and returns right after the edge that took it.
	// The valid stays high into the next call unless that call opens a gap, so it
	// is never dropped and raised within one step.
	task automatic send_request(input req_t req, input logic [ID_W-1:0] id,
			input logic [CNT_W-1:0] period);
		while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {period, id};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		requests_sent++;
	endtask

	// Holds the sender off until every outstanding result beat has been taken.
	// The first edge lets the checker count the beat that was just accepted.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (owed_beats != 0)
			@(posedge clk);
	endtask

	initial begin
		req_t            req;
		logic [ID_W-1:0] id;
		logic [CNT_W-1:0] period;
		int              sel;

		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = ID_W'($urandom_range(65535, 1));
		id_pool[0] = 16'hFFFF;
		id_pool[1] = 16'h0001;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A tick on the empty table gives the lone no-fire beat.
		send_request(REQ_TICK, 16'hFFFF, 16'hFFFF);
		// Null ids are ignored for both add and remove.
		send_request(REQ_ADD, 16'h0000, 16'h0005);
		send_request(REQ_REMOVE, 16'h0000, 16'h0000);
		// Removing an id that was never added.
		send_request(REQ_REMOVE, 16'h1234, 16'h0000);
		// Fill all sixteen slots. The first has a zero period, so it fires on every
		// tick; the second has the longest period.
		send_request(REQ_ADD, 16'hFFFF, 16'h0000);
		send_request(REQ_ADD, 16'h0001, 16'hFFFF);
		send_request(REQ_ADD, 16'h8000, 16'h0002);
		for (int i = 3; i < SLOTS; i++)
			send_request(REQ_ADD, ID_W'(16'h2A00 + i), CNT_W'(i % 4));
		// The table is full now. A new id is refused as full, while a present id
		// is still reported as a duplicate first.
		send_request(REQ_ADD, 16'h7777, 16'h0001);
		send_request(REQ_ADD, 16'hFFFF, 16'h0003);
		// Every slot still holds a count of one, so this tick reports sixteen beats.
		send_request(REQ_TICK, 16'h0000, 16'h0000);
		// Freeing a slot leaves its count running but silent.
		send_request(REQ_REMOVE, 16'h8000, 16'h0000);
		// The unused request code gives a plain done beat.
		send_request(REQ_NONE, 16'h5A5A, 16'hA5A5);
		wait_drained();

		// Random part in four pacing phases: none, sender gaps, receiver stalls,
		// and both. Each phase ends with the sender held until the table is quiet.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_gap_pct = 0;  sink_stall_pct <= 0;  end
				1: begin src_gap_pct = 45; sink_stall_pct <= 0;  end
				2: begin src_gap_pct = 0;  sink_stall_pct <= 45; end
				default: begin src_gap_pct = 17; sink_stall_pct <= 17; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Ids come from a small pool so that duplicates, hits on remove and a
				// full table all keep turning up. Short periods keep ticks busy.
				sel = $urandom_range(99);
				id = id_pool[$urandom_range(POOL_SIZE - 1)];
				if ($urandom_range(9) == 0)
					period = CNT_W'($urandom_range(65535));
				else
					period = CNT_W'($urandom_range(4));
				if (sel < 38) begin
					req = REQ_TICK;
					id = ID_W'($urandom_range(65535));
					period = CNT_W'($urandom_range(65535));
				end else if (sel < 70) begin
					req = REQ_ADD;
				end else if (sel < 94) begin
					req = REQ_REMOVE;
				end else if (sel < 97) begin
					req = ($urandom_range(1) == 0) ? REQ_ADD : REQ_REMOVE;
					id = '0;
				end else begin
					req = REQ_NONE;
					id = ID_W'($urandom_range(65535));
				end
				send_request(req, id, period);
			end
			wait_drained();
		end

		// One scan of the table plus a little slack covers anything still in flight.
		repeat (3 * SLOTS) @(posedge clk);

		$display("Sent %0d requests over four pacing phases, including a full table,",
			requests_sent);
		$display("a sixteen-beat tick and null, duplicate and missing ids; %0d beats compared.",
			beats_checked);
		if (mismatches == 0 && owed_beats == 0) begin
			$display("tb passed");
		end else begin
			$display("%0d mismatches, %0d beats still outstanding", mismatches, owed_beats);
			$display("tb failed");
		end
		$finish;
	end

endmodule

>>> sim.f
design/pttt_pkg.sv
design/pttt_slot_unit.sv
design/periodic_task_tick_table_core.sv
bench/tick_table_checker.sv
bench/tb.sv
